[rtl/core/mi3_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies.
package mi3_pkg;

  localparam int FracBitsDef = 16;
  localparam int ElemW       = 32;
  localparam int NElem       = 9;
  localparam int ProdW       = 2 * ElemW;       // one 32x32 product
  localparam int AdjW        = ProdW + 1;       // exact 2x2 minor
  localparam int HalfW       = AdjW - ElemW;    // upper slice of a minor
  localparam int PartW       = HalfW + ElemW;   // partial product width
  localparam int DetW        = AdjW + ElemW + 1; // exact determinant
  localparam int QuotW       = 32;
  localparam int DivSteps    = QuotW;

  typedef logic [NElem-1:0][ElemW-1:0] mat_t;
  typedef logic [NElem-1:0][AdjW-1:0]  adj_t;

  // Operand indexes of each minor: adj = m[a]*m[b] - m[c]*m[d]
  // Entry order is r1c1, r1c2, r1c3, r2c1, ... r3c3.
  localparam logic [3:0] MinorIdx [NElem][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  localparam logic [QuotW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [QuotW-1:0] SatNeg = 32'h8000_0000;

endpackage

[rtl/core/matrix_inverse_3x3_unit.sv]
// 3x3 matrix inverse by adjugate over determinant, Q(31-F).F fixed point.
// Depends on mi3_pkg, mi3_minor, mi3_det, mi3_div.
//
//  channel   dir  tdata                          tuser
//  s_axis    in   9 x 32b entries, r1c1 lowest   -
//  m_axis    out  9 x 32b entries, r1c1 lowest   singular flag
//
// Stages in order: the minors, the determinant, the divider (prep, range
// check, 32 quotient bits), an output register. One item is accepted per
// cycle unless m_axis stalls; the divider's bit-per-stage pipeline sets
// the depth. Reset clears every valid bit; payload registers are not reset.
// A stall at m_axis freezes the whole pipeline and drops s_axis_tready.
module matrix_inverse_3x3_unit #(
  parameter int FRAC_BITS = mi3_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // r1c1, r1c2, r1c3, r2c1 .. r3c3
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // r1c1, r1c2, r1c3, r2c1 .. r3c3
  output logic [0:0]   m_axis_tuser    // singular
);
  import mi3_pkg::*;

  logic en;
  logic v_min, v_det, v_div;
  mat_t m_min, m_det, m_div;
  adj_t a_min, a_det;
  logic [DetW-1:0] det;
  logic sing;
  logic [NElem-1:0] neg, sat;
  logic [NElem-1:0][QuotW-1:0] quo;

  mat_t out_d, out_q;
  logic sing_q;
  logic valid_q;

  // whole pipeline advances unless a finished item is stuck at the output
  assign en            = !valid_q || m_axis_tready;
  assign s_axis_tready = en;

  mi3_minor u_minor (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid), .mat_i(mat_t'(s_axis_tdata)),
    .valid_o(v_min), .mat_o(m_min), .adj_o(a_min)
  );

  mi3_det u_det (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v_min), .mat_i(m_min), .adj_i(a_min),
    .valid_o(v_det), .mat_o(m_det), .adj_o(a_det), .det_o(det)
  );

  mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v_det), .mat_i(m_det), .adj_i(a_det), .det_i(det),
    .valid_o(v_div), .mat_o(m_div), .sing_o(sing),
    .neg_o(neg), .sat_o(sat), .quo_o(quo)
  );

  // sign and clamp, or pass the input through on a zero determinant
  always_comb begin
    for (int k = 0; k < NElem; k++) begin
      if (sing) begin
        out_d[k] = m_div[k];
      end else if (sat[k]) begin
        out_d[k] = neg[k] ? SatNeg : SatPos;
      end else if (!neg[k]) begin
        out_d[k] = quo[k][QuotW-1] ? SatPos : quo[k];
      end else begin
        out_d[k] = (quo[k] > SatNeg) ? SatNeg : (QuotW'(0) - quo[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= v_div;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      sing_q <= sing;
    end
  end

  assign m_axis_tvalid   = valid_q;
  assign m_axis_tdata    = out_q;
  assign m_axis_tuser[0] = sing_q;

endmodule

[rtl/core/mi3_minor.sv]
// Two-stage adjugate: 18 products, then 9 exact 2x2 minors.
// Depends on mi3_pkg.
module mi3_minor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  mi3_pkg::mat_t mat_i,
  output logic          valid_o,
  output mi3_pkg::mat_t mat_o,
  output mi3_pkg::adj_t adj_o
);
  import mi3_pkg::*;

  logic signed [ProdW-1:0] pa_d [NElem];
  logic signed [ProdW-1:0] pb_d [NElem];
  logic signed [ProdW-1:0] pa_q [NElem];
  logic signed [ProdW-1:0] pb_q [NElem];
  adj_t adj_d, adj_q;
  mat_t m1_q, m2_q;
  logic v1_q, v2_q;

  always_comb begin
    for (int k = 0; k < NElem; k++) begin
      pa_d[k] = $signed(mat_i[MinorIdx[k][0]]) * $signed(mat_i[MinorIdx[k][1]]);
      pb_d[k] = $signed(mat_i[MinorIdx[k][2]]) * $signed(mat_i[MinorIdx[k][3]]);
    end
  end

  always_comb begin
    for (int k = 0; k < NElem; k++) begin
      adj_d[k] = AdjW'(pa_q[k]) - AdjW'(pb_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      m1_q  <= mat_i;
      adj_q <= adj_d;
      m2_q  <= m1_q;
    end
  end

  assign valid_o = v2_q;
  assign mat_o   = m2_q;
  assign adj_o   = adj_q;

endmodule

[rtl/core/mi3_det.sv]
// Two-stage determinant along the first row: split partial products, then sum.
// Depends on mi3_pkg.
module mi3_det (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mi3_pkg::mat_t   mat_i,
  input  mi3_pkg::adj_t   adj_i,
  output logic            valid_o,
  output mi3_pkg::mat_t   mat_o,
  output mi3_pkg::adj_t   adj_o,
  output logic [mi3_pkg::DetW-1:0] det_o
);
  import mi3_pkg::*;

  logic signed [PartW-1:0] lo_d [3];
  logic signed [PartW-1:0] hi_d [3];
  logic signed [PartW-1:0] lo_q [3];
  logic signed [PartW-1:0] hi_q [3];
  logic signed [DetW-1:0]  det_d;
  logic [DetW-1:0] det_q;
  adj_t adj1_q, adj2_q;
  mat_t m1_q, m2_q;
  logic v1_q, v2_q;

  // minor k*3 (cofactor of r1cK) times r1cK, minor cut at bit 32
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      lo_d[t] = $signed({1'b0, adj_i[3*t][ElemW-1:0]}) * $signed(mat_i[t]);
      hi_d[t] = $signed(adj_i[3*t][AdjW-1:ElemW]) * $signed(mat_i[t]);
    end
  end

  always_comb begin
    det_d = '0;
    for (int t = 0; t < 3; t++) begin
      det_d = det_d + (DetW'(hi_q[t]) <<< ElemW) + DetW'(lo_q[t]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      adj1_q <= adj_i;
      m1_q   <= mat_i;
      det_q  <= det_d;
      adj2_q <= adj1_q;
      m2_q   <= m1_q;
    end
  end

  assign valid_o = v2_q;
  assign mat_o   = m2_q;
  assign adj_o   = adj2_q;
  assign det_o   = det_q;

endmodule

[rtl/core/mi3_div.sv]
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Depends on mi3_pkg.
module mi3_div #(
  parameter int FRAC_BITS = mi3_pkg::FracBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mi3_pkg::mat_t   mat_i,
  input  mi3_pkg::adj_t   adj_i,
  input  logic [mi3_pkg::DetW-1:0] det_i,
  output logic            valid_o,
  output mi3_pkg::mat_t   mat_o,
  output logic            sing_o,
  output logic [mi3_pkg::NElem-1:0] neg_o,
  output logic [mi3_pkg::NElem-1:0] sat_o,
  output logic [mi3_pkg::NElem-1:0][mi3_pkg::QuotW-1:0] quo_o
);
  import mi3_pkg::*;

  localparam int NumW  = AdjW + 2 * FRAC_BITS;
  localparam int DShW  = DetW + QuotW;
  localparam int CW    = (NumW > DShW) ? NumW : DShW;
  localparam int NStg  = DivSteps + 2;  // prep, range check, quotient bits

  logic [CW-1:0]    rem_q [NStg][NElem];
  logic [QuotW-1:0] quo_q [NStg][NElem];
  logic [NElem-1:0] neg_q [NStg];
  logic [NElem-1:0] sat_q [NStg];
  logic [DetW-1:0]  den_q [NStg];
  mat_t             mat_q [NStg];
  logic             sng_q [NStg];
  logic             vld_q [NStg];

  // prep: magnitudes, signs, scaled numerators, zero test
  logic [CW-1:0]    rem0_d [NElem];
  logic [NElem-1:0] neg0_d;
  logic [DetW-1:0]  den0_d;
  logic [AdjW-1:0]  amag;

  always_comb begin
    den0_d = det_i[DetW-1] ? (DetW'(0) - det_i) : det_i;
    for (int k = 0; k < NElem; k++) begin
      amag      = adj_i[k][AdjW-1] ? (AdjW'(0) - adj_i[k]) : adj_i[k];
      rem0_d[k] = CW'(amag) << (2 * FRAC_BITS);
      neg0_d[k] = adj_i[k][AdjW-1] ^ det_i[DetW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NElem; k++) begin
        rem_q[0][k] <= rem0_d[k];
        quo_q[0][k] <= '0;
      end
      neg_q[0] <= neg0_d;
      sat_q[0] <= '0;
      den_q[0] <= den0_d;
      mat_q[0] <= mat_i;
      sng_q[0] <= (det_i == '0);
    end
  end

  // range check: quotient would not fit 32 bits
  logic [NElem-1:0] sat1_d;
  always_comb begin
    for (int k = 0; k < NElem; k++) begin
      sat1_d[k] = rem_q[0][k] >= (CW'(den_q[0]) << QuotW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[1] <= rem_q[0];
      quo_q[1] <= quo_q[0];
      neg_q[1] <= neg_q[0];
      sat_q[1] <= sat1_d;
      den_q[1] <= den_q[0];
      mat_q[1] <= mat_q[0];
      sng_q[1] <= sng_q[0];
    end
  end

  for (genvar s = 2; s < NStg; s++) begin : g_step
    localparam int Bit = QuotW - 1 - (s - 2);
    logic [CW-1:0]    trial;
    logic [CW-1:0]    rem_d [NElem];
    logic [QuotW-1:0] quo_d [NElem];

    always_comb begin
      trial = CW'(den_q[s-1]) << Bit;
      for (int k = 0; k < NElem; k++) begin
        rem_d[k] = rem_q[s-1][k];
        quo_d[k] = quo_q[s-1][k];
        if (rem_q[s-1][k] >= trial) begin
          rem_d[k]      = rem_q[s-1][k] - trial;
          quo_d[k][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        neg_q[s] <= neg_q[s-1];
        sat_q[s] <= sat_q[s-1];
        den_q[s] <= den_q[s-1];
        mat_q[s] <= mat_q[s-1];
        sng_q[s] <= sng_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStg; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < NStg; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign mat_o   = mat_q[NStg-1];
  assign sing_o  = sng_q[NStg-1];
  assign neg_o   = neg_q[NStg-1];
  assign sat_o   = sat_q[NStg-1];
  always_comb begin
    for (int k = 0; k < NElem; k++) quo_o[k] = quo_q[NStg-1][k];
  end

endmodule

[rtl/core/mi3_checker.sv]
// Port-level checks for matrix_inverse_3x3_unit, attached by bind.
// Depends on matrix_inverse_3x3_unit ports only.
module mi3_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // no item out while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // held output blocks the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // free output lets input in
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked with output free");

  // stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output item changed");

endmodule

bind matrix_inverse_3x3_unit mi3_checker u_mi3_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);

[sim/tb.sv]
// Testbench for matrix_inverse_3x3_unit: random and directed 3x3 matrices,
// checked against an in-bench predictor of adjugate over determinant.
// Depends on mi3_pkg and the RTL of matrix_inverse_3x3_unit.
module tb;
  import mi3_pkg::*;

  localparam int Frac = FracBitsDef;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [8:0][31:0] ent;
    logic             sing;
  } inv_res_t;

  // Holds the predicted inverses in arrival order and checks results.
  class inverse_board;
    inv_res_t pending[$];
    int       errors;

    function automatic logic [31:0] div_sat(logic signed [127:0] num,
                                            logic signed [127:0] den);
      logic                neg;
      logic [255:0]        n;
      logic [255:0]        d;
      logic [255:0]        q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      n = n << (2 * Frac);
      q = n / d;
      if (!neg) return (q > 256'h7FFF_FFFF) ? SatPos : q[31:0];
      return (q > 256'h8000_0000) ? SatNeg : (32'd0 - q[31:0]);
    endfunction

    function void note_matrix(logic [8:0][31:0] m);
      logic signed [127:0] a[9];
      logic signed [127:0] adj[9];
      logic signed [127:0] det;
      inv_res_t r;
      for (int i = 0; i < 9; i++) a[i] = $signed(m[i]);
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = adj[0] * a[0] + adj[3] * a[1] + adj[6] * a[2];
      if (det == 0) begin
        r.ent = m;
        r.sing = 1'b1;
      end else begin
        for (int i = 0; i < 9; i++) r.ent[i] = div_sat(adj[i], det);
        r.sing = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [287:0] data, logic sing);
      inv_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", data);
        return;
      end
      e = pending.pop_front();
      if (e.sing !== sing) begin
        errors++;
        if (errors <= 10) $display("singular exp %b got %b", e.sing, sing);
      end
      for (int i = 0; i < 9; i++)
        if (e.ent[i] !== data[32*i +: 32]) begin
          errors++;
          if (errors <= 10)
            $display("entry %0d exp %h got %h", i, e.ent[i], data[32*i +: 32]);
        end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  inverse_board board = new();
  bit           calm = 1'b0;   // no idling on either side while set
  int           stall_cnt = 0;
  bit           timed_out = 1'b0;

  matrix_inverse_3x3_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: sample at the rising edge, update tready at the falling one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser[0]);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
  end

  always @(negedge clk_i)
    if (rst_ni) m_axis_tready <= calm || ($urandom_range(99) >= 11);

  always @(posedge clk_i)
    if (stall_cnt >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom_range(65536 * 4) - 32'(65536 * 2);
      4: return 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept
  // with tvalid still high, so the next item can follow with no gap.
  task automatic send_matrix(logic [8:0][31:0] m);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= m;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_matrix(m);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [8:0][31:0] m;
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: identity, zero, extremes, singular rows, tiny determinant.
    m = '0; m[0] = 32'h10000; m[4] = 32'h10000; m[8] = 32'h10000;
    send_matrix(m);
    send_matrix('0);
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'hFFFF_FFFF}});
    m = '0; m[0] = 32'h1; m[4] = 32'h1; m[8] = 32'h1;
    send_matrix(m);                       // saturating inverse
    m = '0; m[0] = 32'h8000_0000; m[4] = 32'h7FFF_FFFF; m[8] = 32'h8000_0000;
    send_matrix(m);
    m = '0; m[0] = 32'hFFFF_0000; m[4] = 32'h20000; m[8] = 32'h8000;
    send_matrix(m);
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 9; i++) m[i] = rand_entry();
      m[6] = m[0]; m[7] = m[1]; m[8] = m[2];   // two equal rows
      send_matrix(m);
    end
    m = {32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
         32'h0, 32'h1234_5678, 32'hFEDC_BA98, 32'h1, 32'hFFFF_FFFE};
    send_matrix(m);
    drain();

    for (int n = 0; n < 550; n++) begin
      calm = (n >= 200 && n < 300);
      for (int i = 0; i < 9; i++) m[i] = rand_entry();
      if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) m[3+i] = m[i];
      send_matrix(m);
      if (n == 400) drain();
    end
    calm = 1'b0;
    drain();
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/mi3_pkg.sv
rtl/core/mi3_minor.sv
rtl/core/mi3_det.sv
rtl/core/mi3_div.sv
rtl/core/matrix_inverse_3x3_unit.sv
rtl/core/mi3_checker.sv
sim/tb.sv
